/* sv/assert_macros.svh */
// assertion macros shared by the hash table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define OAHT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("oaht assertion failed");

// condition that must never hold outside reset
`define OAHT_ASSERT_NEVER(name, expr) \
  `OAHT_ASSERT(name, !(expr))

`endif

/* sv/oaht_pkg.sv */
// shared constants and codes of the open addressing hash table
package oaht_pkg;

  // default geometry
  localparam int unsigned DEF_TABLE_SIZE = 1021;
  localparam int unsigned DEF_KEY_WIDTH  = 32;

  // fixed field widths of the request and response words
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OUT_W    = 10;
  localparam int unsigned LIMIT_W  = 10;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-1:0]  ADDR_LIMIT  = 3'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd510;

  // key bits reduced per cycle by the home slot unit
  localparam int unsigned MOD_DIGIT_BITS = 8;

  // request operations
  localparam logic FUNC_SEARCH = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage

/* sv/oaht_if.sv */
// request and response channel interfaces of the hash table
interface oaht_req_if import oaht_pkg::*; #(
  parameter int unsigned KEY_WIDTH = DEF_KEY_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [KEY_WIDTH-1:0] key;

  modport source (output valid, func, key, input ready);
  modport sink (input valid, func, key, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OUT_W-1:0]    position;
  logic [OUT_W-1:0]    probe_count;
  logic [OUT_W-1:0]    entry_total;

  modport source (output valid, status, position, probe_count, entry_total, input ready);
  modport sink (input valid, status, position, probe_count, entry_total, output ready);
endinterface

/* sv/oaht_ram.sv */
// generic simple dual port ram with registered read
module oaht_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/oaht_mod.sv */
// home slot unit: key modulo table size, one digit of key bits per cycle
`include "assert_macros.svh"

module oaht_mod import oaht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int unsigned KEY_WIDTH  = DEF_KEY_WIDTH,
  localparam int unsigned PW = $clog2(TABLE_SIZE)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  output logic                 done_o,
  output logic [PW-1:0]        rem_o
);

  localparam int unsigned NSTEP = (KEY_WIDTH + MOD_DIGIT_BITS - 1) / MOD_DIGIT_BITS;
  localparam int unsigned PADW  = NSTEP * MOD_DIGIT_BITS;
  localparam int unsigned SW    = $clog2(NSTEP + 1);

  logic [PADW-1:0] key_q, key_d;
  logic [PW-1:0]   rem_q, rem_d;
  logic [SW-1:0]   cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [PW-1:0]   rem_step;

  // one digit of restoring reduction, remainder stays below table size
  always_comb begin
    logic [PW:0]   t;
    logic [PW-1:0] r;
    r = rem_q;
    for (int j = 0; j < MOD_DIGIT_BITS; j++) begin
      t = {r, key_q[PADW-1-j]};
      if (t >= (PW+1)'(TABLE_SIZE)) begin
        t = t - (PW+1)'(TABLE_SIZE);
      end
      r = t[PW-1:0];
    end
    rem_step = r;
  end

  // step sequencing
  always_comb begin
    key_d  = key_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      key_d = PADW'(key_i);
      rem_d = '0;
      cnt_d = SW'(NSTEP);
    end else if (cnt_q != '0) begin
      key_d  = key_q << MOD_DIGIT_BITS;
      rem_d  = rem_step;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == SW'(1));
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `OAHT_ASSERT(a_rem_in_range, done_q |-> (PW+1)'(rem_q) < (PW+1)'(TABLE_SIZE))
  `OAHT_ASSERT_NEVER(a_start_while_busy, start_i && (cnt_q != '0))

endmodule

/* sv/open_addressing_hash_table_unit.sv */
// top level of the open addressing hash table with triangular probing
`include "assert_macros.svh"

// Keys and their valid marks live in one memory of TABLE_SIZE words of
// KEY_WIDTH+1 bits with a registered read. After reset the block runs a
// clearing pass over all TABLE_SIZE slots, one slot per cycle, and takes no
// request meanwhile; the probe limit register can be written at any time.
// A request is taken only while the engine is idle. It then passes through
// the home slot unit, which folds eight key bits per cycle, launches the
// home slot read, and visits one slot after another, each visit waiting
// on the memory read of that slot; the engine returns to idle only once
// its response is loaded into the output register.
// The response sits in an output register, so the next request is taken
// while it waits; an insert writes its slot in the cycle the response is
// formed, well before any later read can reach the memory.
module open_addressing_hash_table_unit import oaht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int unsigned KEY_WIDTH  = DEF_KEY_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  oaht_req_if.sink          req_i,
  oaht_rsp_if.source        rsp_o
);

  localparam int unsigned PW   = $clog2(TABLE_SIZE);
  localparam int unsigned CW   = $clog2(TABLE_SIZE + 1);
  localparam int unsigned CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned XW   = (CW > OUT_W) ? CW : OUT_W;
  localparam int unsigned MW   = KEY_WIDTH + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HASH  = 4'b0100,
    S_PROBE = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [PW-1:0]        clr_q, clr_d;
  logic [PW-1:0]        p_q, p_d;
  logic [CW-1:0]        c_q, c_d;
  logic [CW-1:0]        count_q, count_d;
  logic [LIMIT_W-1:0]   limit_q;
  logic [KEY_WIDTH-1:0] k_q;
  logic                 func_q;

  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [OUT_W-1:0]     out_pos_q, out_pos_d;
  logic [OUT_W-1:0]     out_probe_q, out_probe_d;
  logic [OUT_W-1:0]     out_total_q, out_total_d;
  logic                 out_load;

  logic                 ram_we, ram_re;
  logic [PW-1:0]        ram_waddr, ram_raddr;
  logic [MW-1:0]        ram_wdata, ram_rdata;

  logic                 accept, mod_done;
  logic [PW-1:0]        mod_rem;

  logic                 slot_hit, slot_empty, exhaust, finish, out_free, insert_ok;
  logic [CW-1:0]        c_inc;
  logic [PW:0]          p_sum;
  logic [PW-1:0]        p_next;
  logic [XW-1:0]        pos_x, probe_x, total_x;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LIMIT) ? APB_DW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_LIMIT)) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // request handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);

  // home slot reduction
  oaht_mod #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (req_i.key),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // slot memory: valid mark above the key
  oaht_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // slot compare and next triangular position
  assign slot_empty = !ram_rdata[KEY_WIDTH];
  assign slot_hit   = ram_rdata[KEY_WIDTH] && (ram_rdata[KEY_WIDTH-1:0] == k_q);
  assign c_inc      = c_q + 1'b1;
  assign exhaust    = !slot_hit && !slot_empty && (c_inc == CW'(TABLE_SIZE));
  assign finish     = slot_hit || slot_empty || exhaust;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign insert_ok  = (func_q == FUNC_INSERT) && slot_empty
                      && (CMPW'(c_q) < CMPW'(limit_q));
  assign p_sum      = (PW+1)'(p_q) + (PW+1)'(c_inc);
  assign p_next     = (p_sum >= (PW+1)'(TABLE_SIZE))
                      ? PW'(p_sum - (PW+1)'(TABLE_SIZE)) : p_sum[PW-1:0];

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    p_d       = p_q;
    c_d       = c_q;
    count_d   = count_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = p_q;
    ram_wdata = {1'b1, k_q};
    ram_re    = 1'b0;
    ram_raddr = mod_rem;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if ((PW+1)'(clr_q) == (PW+1)'(TABLE_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          ram_re  = 1'b1;
          p_d     = mod_rem;
          c_d     = '0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!finish) begin
          ram_re    = 1'b1;
          ram_raddr = p_next;
          p_d       = p_next;
          c_d       = c_inc;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (insert_ok) begin
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // response word
  always_comb begin
    if (func_q == FUNC_SEARCH) begin
      if (slot_hit) begin
        out_status_d = ST_FOUND;
      end else if (slot_empty) begin
        out_status_d = ST_NOTFOUND;
      end else begin
        out_status_d = ST_FULL;
      end
    end else begin
      if (slot_hit) begin
        out_status_d = ST_DUP;
      end else if (insert_ok) begin
        out_status_d = ST_INSERTED;
      end else begin
        out_status_d = ST_FULL;
      end
    end
    pos_x       = (out_status_d == ST_FULL) ? XW'(TABLE_SIZE) : XW'(p_q);
    probe_x     = exhaust ? XW'(c_inc) : XW'(c_q);
    total_x     = XW'(count_d);
    out_pos_d   = pos_x[OUT_W-1:0];
    out_probe_d = probe_x[OUT_W-1:0];
    out_total_d = total_x[OUT_W-1:0];
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    c_q <= c_d;
    if (accept) begin
      k_q    <= req_i.key;
      func_q <= req_i.func;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
      out_probe_q  <= out_probe_d;
      out_total_q  <= out_total_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.position    = out_pos_q;
  assign rsp_o.probe_count = out_probe_q;
  assign rsp_o.entry_total = out_total_q;

  `OAHT_ASSERT_NEVER(a_count_range, count_q > CW'(TABLE_SIZE))
  `OAHT_ASSERT(a_pos_range, (state_q == S_PROBE) |-> (PW+1)'(p_q) < (PW+1)'(TABLE_SIZE))
  `OAHT_ASSERT(a_insert_counts, (state_q == S_PROBE && ram_we) |=> count_q == $past(count_q) + 1'b1)
  `OAHT_ASSERT_NEVER(a_no_read_on_write, ram_we && ram_re)

endmodule
